// File: hw/rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_OFFSET_BITS = 32;

    localparam int PAT_STORE   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int PAT_BITS    = PAT_STORE * 8;
    localparam int PAT_REGS    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_LEN_W   = 6;
    localparam int LEN_W       = 7;
    localparam int OFFSET_OUT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd5;

    localparam logic [PAT_STORE-1:0] CARE_RESET = '1;
    localparam logic [CFG_LEN_W-1:0] LEN_RESET  = 6'd1;

    typedef struct packed {
        logic [PAT_BITS-1:0]  pattern;
        logic [PAT_STORE-1:0] care;
        logic [CFG_LEN_W-1:0] length;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/wbps_cfg.sv
// Configuration register file: pattern bytes, care mask and pattern length.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cfg
    import wbps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_reg;
    logic [PAT_STORE-1:0]                care_reg;
    logic [CFG_LEN_W-1:0]                len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            care_reg <= CARE_RESET;
            len_reg  <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_0: pat_reg[0] <= cfg_data;
                REG_PATTERN_1: pat_reg[1] <= cfg_data;
                REG_PATTERN_2: pat_reg[2] <= cfg_data;
                REG_PATTERN_3: pat_reg[3] <= cfg_data;
                REG_CARE_MASK: care_reg   <= cfg_data[PAT_STORE-1:0];
                REG_PAT_LEN:   len_reg    <= cfg_data[CFG_LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.pattern = pat_reg;
    assign cfg.care    = care_reg;
    assign cfg.length  = len_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wbps_match.sv
// Parallel window compare: tests the newest bytes against the pattern and
// computes the match start offset. Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  wire cfg_t                             cfg,
    input  wire logic [MAX_PATTERN-1:0][7:0]      window,
    input  wire logic [OFFSET_BITS-1:0]           count,
    output logic                                  hit,
    output logic [OFFSET_OUT_W-1:0]               offset
);

    localparam int EXT_W = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;

    logic [LEN_W-1:0]       len_raw;
    logic [LEN_W-1:0]       len_eff;
    logic [MAX_PATTERN-1:0] pos_ok;
    logic [OFFSET_BITS-1:0] diff;
    logic [EXT_W-1:0]       diff_ext;

    assign len_raw = {1'b0, cfg.length};
    assign len_eff = (len_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_raw;

    // window[k] (k = 0 newest) lines up with pattern byte len - 1 - k
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_pos
        logic [LEN_W-1:0] pidx;
        logic             active;
        logic             stored;
        logic [7:0]       pbyte;

        assign pidx   = len_eff - LEN_W'(k + 1);
        assign active = LEN_W'(k) < len_eff;
        assign stored = (pidx[LEN_W-1:PAT_IDX_W] == '0);
        assign pbyte  = cfg.pattern[{pidx[PAT_IDX_W-1:0], 3'b000} +: 8];
        assign pos_ok[k] = !active || !stored || !cfg.care[pidx[PAT_IDX_W-1:0]]
                           || (window[k] == pbyte);
    end

    assign hit = (len_eff != '0) && (&pos_ok) && (count >= OFFSET_BITS'(len_eff));

    assign diff     = count - OFFSET_BITS'(len_eff);
    assign diff_ext = EXT_W'(diff);
    assign offset   = diff_ext[OFFSET_OUT_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner: input stage, scan state
// and output register. Depends on wbps_pkg, wbps_cfg and wbps_match.
//
// Usage:
//   s_* carries the scanned region, one byte per word (s_tdata), with
//   s_tlast on the final byte. m_* returns at most one word per region:
//   m_tuser = found, m_tdata = match start offset (0 when not found).
//   cfg_* writes the pattern registers (index 0..3 pattern bytes, 4 care
//   mask, 5 pattern length); it is always ready and other indexes are
//   ignored. Write config only while no region is being scanned.
//   Path: a byte is first captured in the input register, then one parallel
//   compare of all MAX_PATTERN window positions loads its result into the
//   output register that drives m_*. Throughput: one byte per cycle while
//   no result waits on m_tready (see Stall).
//   After the first match the rest of the region yields nothing; the
//   window, byte count and match flag clear after the last byte.
//   Reset: registers return to their defaults (length 1, care all ones,
//   pattern zero) and the scan state clears.
//   Stall: while a result waits on m_tready the input register holds and
//   s_tready drops once it is full; no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,    // [7:0] data_byte
    input  wire logic                    s_tlast,    // last_byte

    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OFFSET_OUT_W-1:0]      m_tdata,    // [31:0] match_offset
    output logic [0:0]                   m_tuser,    // [0] found

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t cfg;

    logic                              s1_valid_reg;
    logic [7:0]                        s1_byte_reg;
    logic                              s1_last_reg;

    logic [MAX_PATTERN-1:0][7:0]       window_reg;
    logic [MAX_PATTERN-1:0][7:0]       window_next;
    logic [OFFSET_BITS-1:0]            cnt_reg;
    logic [OFFSET_BITS-1:0]            cnt_next;
    logic                              rep_reg;
    logic                              rep_next;

    logic                              out_valid_reg;
    logic                              out_found_reg;
    logic [OFFSET_OUT_W-1:0]           out_offset_reg;

    logic [MAX_PATTERN-1:0][7:0]       win_shift;
    logic [OFFSET_BITS-1:0]            cnt_inc;
    logic                              hit;
    logic [OFFSET_OUT_W-1:0]           hit_offset;
    logic                              adv;
    logic                              fire1;
    logic                              res_found;
    logic                              res_valid;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        win_shift[0] = s1_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_shift[k] = window_reg[k-1];
        end
    end

    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    wbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .cfg    (cfg),
        .window (win_shift),
        .count  (cnt_inc),
        .hit    (hit),
        .offset (hit_offset)
    );

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv;
    assign fire1    = s1_valid_reg && adv;

    assign res_found = !rep_reg && hit;
    assign res_valid = res_found || (s1_last_reg && !rep_reg);

    always_comb
    begin
        window_next = window_reg;
        cnt_next    = cnt_reg;
        rep_next    = rep_reg;
        if (fire1)
        begin
            if (s1_last_reg)
            begin
                window_next = '0;
                cnt_next    = '0;
                rep_next    = 1'b0;
            end
            else
            begin
                window_next = win_shift;
                cnt_next    = cnt_inc;
                rep_next    = rep_reg || res_found;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            window_reg    <= '0;
            cnt_reg       <= '0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= fire1 && res_valid;
            end
            window_reg <= window_next;
            cnt_reg    <= cnt_next;
            rep_reg    <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (fire1 && res_valid)
        begin
            out_found_reg  <= res_found;
            out_offset_reg <= res_found ? hit_offset : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_offset_reg;
    assign m_tuser[0] = out_found_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found word carries a nonzero offset");

    a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        fire1 && rep_reg |-> !res_valid)
        else $error("result produced after match already reported");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire1 && s1_last_reg |=> cnt_reg == '0 && !rep_reg)
        else $error("scan state not cleared after last byte");

    a_reported_count: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg |-> cnt_reg != '0)
        else $error("match flag set with zero byte count");

endmodule

`default_nettype wire

// File: dv/wbps_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard byte pattern scanner: watches the config, input and
// result channels, predicts each result word and compares it in order. Depends on wbps_pkg.

module wbps_checker
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OFFSET_OUT_W-1:0]  m_tdata,
    input  logic [0:0]               m_tuser,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       found_seen,
    output int                       miss_seen
);

    typedef struct packed {
        logic                    found;
        logic [OFFSET_OUT_W-1:0] offset;
    } scan_result_t;

    localparam logic [OFFSET_BITS-1:0] COUNT_SAT = '1;

    logic [7:0]             window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] byte_count;
    logic                   reported;
    logic [PAT_BITS-1:0]    pat;
    logic [PAT_STORE-1:0]   care;
    logic [CFG_LEN_W-1:0]   plen;
    scan_result_t           expected_results [$];
    int                     errors;
    int                     hits;
    int                     misses;

    // window[0] is the newest byte; pattern byte j lines up with window[len-1-j]
    function automatic logic window_hit(int len);
        for (int j = 0; j < len; j++)
        begin
            if (j < PAT_STORE && care[j] && window[len-1-j] != pat[j*8 +: 8])
                return 1'b0;
        end
        return len != 0;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < MAX_PATTERN; i++)
            window[i] = 8'h00;
        byte_count = '0;
        reported   = 1'b0;
    endtask

    task automatic queue_result(input scan_result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        int           len;
        scan_result_t r;
        len = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
        for (int i = MAX_PATTERN - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (byte_count != COUNT_SAT)
            byte_count++;
        if (!reported && len != 0 && byte_count >= len && window_hit(len))
        begin
            r.found  = 1'b1;
            r.offset = OFFSET_OUT_W'(64'(byte_count) - 64'(len));
            queue_result(r);
            reported = 1'b1;
        end
        else if (last && !reported)
        begin
            r.found  = 1'b0;
            r.offset = '0;
            queue_result(r);
        end
        if (last)
            clear_scan();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t exp_r;
        if (!rst_n)
        begin
            clear_scan();
            pat  = '0;
            care = CARE_RESET;
            plen = LEN_RESET;
            expected_results.delete();
            errors = 0;
            hits   = 0;
            misses = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_0: pat[0*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
                    REG_PATTERN_1: pat[1*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
                    REG_PATTERN_2: pat[2*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
                    REG_PATTERN_3: pat[3*CFG_DATA_W +: CFG_DATA_W] = cfg_data;
                    REG_CARE_MASK: care = cfg_data[PAT_STORE-1:0];
                    REG_PAT_LEN:   plen = cfg_data[CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (m_tuser[0] === 1'b1)
                    hits++;
                else
                    misses++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got found %b offset %0d",
                             $time, m_tuser[0], m_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser[0] !== exp_r.found || m_tdata !== exp_r.offset)
                    begin
                        errors++;
                        $display("%0t: mismatch found exp %b got %b, offset exp %0d got %0d",
                                 $time, exp_r.found, m_tuser[0], exp_r.offset, m_tdata);
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
        found_seen <= hits;
        miss_seen  <= misses;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, region stimulus, config writes and result
// back-pressure. Depends on wbps_pkg, wbps_checker and wildcard_byte_pattern_scanner_top.

module tb_top;
    import wbps_pkg::*;

    localparam int ITEM_TARGET   = 1100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REGION    = 100;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_EVERY_4TH} rx_mode_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OFFSET_OUT_W-1:0] m_tdata;
    logic [0:0]              m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int found_seen;
    int miss_seen;

    bit                   hold_req;
    int                   items_sent;
    int                   regions_sent;
    int                   settings_used;
    int                   burst_left;
    int                   idle_cycles = 0;
    logic [PAT_BITS-1:0]  gen_pat;
    logic [PAT_STORE-1:0] gen_care;
    int                   gen_len;

    wildcard_byte_pattern_scanner_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wbps_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_scanner(input logic [PAT_BITS-1:0] p, input logic [PAT_STORE-1:0] c,
                                   input logic [CFG_LEN_W-1:0] len);
        write_reg(REG_PATTERN_0, p[0*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_1, p[1*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_2, p[2*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_3, p[3*CFG_DATA_W +: CFG_DATA_W]);
        if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, {$urandom, $urandom});
        write_reg(REG_CARE_MASK, {$urandom, c});
        write_reg(REG_PAT_LEN, {26'($urandom), 32'($urandom), len});
        cfg_valid <= 1'b0;
        gen_pat  = p;
        gen_care = c;
        gen_len  = (len > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : len;
        settings_used++;
    endtask

    // bursts of random length separated by random gaps
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random bytes, optionally drawn from the pattern itself, optionally with planted copies
    task automatic send_region(input int n, input bit plant);
        logic [7:0] region_bytes [MAX_REGION];
        bit         near_miss;
        int         pos;
        near_miss = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            if (near_miss && gen_len > 0)
                region_bytes[i] = gen_pat[8*$urandom_range(0, gen_len - 1) +: 8];
            else
                region_bytes[i] = 8'($urandom_range(0, 255));
        end
        if (plant && gen_len > 0 && n >= gen_len)
        begin
            repeat ($urandom_range(1, 2))
            begin
                pos = $urandom_range(0, n - gen_len);
                for (int j = 0; j < gen_len; j++)
                    if (gen_care[j])
                        region_bytes[pos+j] = gen_pat[8*j +: 8];
            end
        end
        for (int i = 0; i < n; i++)
            send_word(region_bytes[i], i == n - 1);
        regions_sent++;
    endtask

    initial
    begin
        rx_mode_t mode;
        int       left;
        m_tready = 1'b0;
        mode     = RX_ALWAYS;
        left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_MOSTLY:  m_tready <= ($urandom_range(0, 9) < 7);
                RX_SPARSE:  m_tready <= ($urandom_range(0, 9) < 3);
                default:    m_tready <= (left % 4 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PAT_BITS-1:0]  p;
        logic [PAT_STORE-1:0] c;
        logic [CFG_LEN_W-1:0] len;
        int                   phase;
        int                   sel;
        int                   n;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        regions_sent  = 0;
        settings_used = 0;
        burst_left    = 0;
        gen_pat       = '0;
        gen_care      = CARE_RESET;
        gen_len       = LEN_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: single zero byte; match on the last byte, early match, plain miss
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hAA, 1'b1);
        send_word(8'hFF, 1'b1);
        regions_sent += 3;
        settle();

        // AA ?? CC with a wildcard in the middle; spare indexes must be ignored
        write_reg(REG_UNUSED_A, '1);
        write_reg(REG_UNUSED_B, '1);
        p = '0;
        p[0 +: 64]   = 64'h0000_0000_00CC_55AA;
        p[128 +: 64] = {$urandom, $urandom};
        p[192 +: 64] = '1;
        program_scanner(p, ~32'h0000_0002, 6'd3);
        send_word(8'hAA, 1'b0);
        send_word(8'hCC, 1'b1);
        send_word(8'h11, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hCC, 1'b0);
        send_word(8'h7E, 1'b1);
        regions_sent += 2;
        settle();

        // zero length never matches
        program_scanner(p, ~32'h0000_0002, 6'd0);
        send_word(8'hAA, 1'b0);
        send_word(8'h00, 1'b1);
        regions_sent++;
        settle();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            for (int k = 0; k < PAT_REGS; k++)
                p[k*CFG_DATA_W +: CFG_DATA_W] = {$urandom, $urandom};
            sel = $urandom_range(0, 9);
            if (sel == 0)
                p = '0;
            else if (sel == 1)
                p = '1;
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: c = '1;
                3:       c = '0;
                4:       c = $urandom & $urandom;
                default: c = $urandom | $urandom;
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0:       len = 6'd0;
                1:       len = 6'($urandom_range(33, 63));
                2:       len = 6'd32;
                3:       len = 6'd1;
                default: len = 6'($urandom_range(2, 12));
            endcase
            program_scanner(p, c, len);

            // receiver holds off while short regions pile up behind it
            if (phase == 3)
            begin
                hold_req = 1'b1;
                repeat (16) send_region($urandom_range(1, 2), 1'b0);
            end

            repeat ($urandom_range(3, 8))
            begin
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    n = $urandom_range(1, 3);
                else if (sel < 88)
                    n = $urandom_range(1, 40);
                else
                    n = $urandom_range(41, MAX_REGION);
                send_region(n, $urandom_range(0, 9) < 7);
            end
            settle();
            phase++;
        end

        $display("Scanned %0d bytes in %0d regions under %0d pattern settings",
                 items_sent, regions_sent, settings_used);
        $display("Checked %0d found and %0d not-found results", found_seen, miss_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_match.sv
hw/rtl/wildcard_byte_pattern_scanner_top.sv
dv/wbps_checker.sv
dv/tb_top.sv
